// File: rtl/altitude_table_interpolator_unit_macros.svh
// assertion macros shared by the altitude table interpolator rtl
`ifndef ALTITUDE_TABLE_INTERPOLATOR_UNIT_MACROS_SVH
`define ALTITUDE_TABLE_INTERPOLATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// condition implies check in the same cycle
`define ATIU_CHECK_SAME(label, cond, chk) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (chk)) \
    else $error("same-cycle check failed");
// condition implies check in the next cycle
`define ATIU_CHECK_NEXT(label, cond, chk) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (chk)) \
    else $error("next-cycle check failed");
`else
`define ATIU_CHECK_SAME(label, cond, chk)
`define ATIU_CHECK_NEXT(label, cond, chk)
`endif

`endif

// File: rtl/atip_pkg.sv
// types, constants and breakpoint tables of the altitude table interpolator
package atip_pkg;

  localparam int STORED_POINTS = 20;
  localparam int ALT_W = 18;
  localparam int VAL_W = 24;
  localparam int OFF_W = 17;
  localparam int SEG_W = 5;
  localparam int PROD_W = VAL_W + OFF_W;
  localparam int QUO_W = VAL_W;
  localparam int STEP_W = 5;
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic             oor;
    logic [SEG_W-1:0] seg;
    logic [OFF_W-1:0] off;
  } q_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEARCH,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_FIN
  } back_state_t;

  function automatic logic signed [ALT_W-1:0] alt_pt(input logic [SEG_W-1:0] idx);
    logic signed [ALT_W-1:0] v;
    case (idx)
      5'd0:  v = 18'sd0;
      5'd1:  v = 18'sd1000;
      5'd2:  v = 18'sd2000;
      5'd3:  v = 18'sd3000;
      5'd4:  v = 18'sd4000;
      5'd5:  v = 18'sd5000;
      5'd6:  v = 18'sd6000;
      5'd7:  v = 18'sd7000;
      5'd8:  v = 18'sd8000;
      5'd9:  v = 18'sd9000;
      5'd10: v = 18'sd10000;
      5'd11: v = 18'sd15000;
      5'd12: v = 18'sd20000;
      5'd13: v = 18'sd25000;
      5'd14: v = 18'sd30000;
      5'd15: v = 18'sd40000;
      5'd16: v = 18'sd50000;
      5'd17: v = 18'sd60000;
      5'd18: v = 18'sd70000;
      5'd19: v = 18'sd80000;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] grav_pt(input logic [SEG_W-1:0] idx);
    logic [VAL_W-1:0] v;
    case (idx)
      5'd0:  v = 24'd9807000;
      5'd1:  v = 24'd9804000;
      5'd2:  v = 24'd9801000;
      5'd3:  v = 24'd9797000;
      5'd4:  v = 24'd9794000;
      5'd5:  v = 24'd9791000;
      5'd6:  v = 24'd9788000;
      5'd7:  v = 24'd9785000;
      5'd8:  v = 24'd9782000;
      5'd9:  v = 24'd9779000;
      5'd10: v = 24'd9776000;
      5'd11: v = 24'd9761000;
      5'd12: v = 24'd9745000;
      5'd13: v = 24'd9730000;
      5'd14: v = 24'd9715000;
      5'd15: v = 24'd9684000;
      5'd16: v = 24'd9654000;
      5'd17: v = 24'd9624000;
      5'd18: v = 24'd9594000;
      5'd19: v = 24'd9564000;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] dens_pt(input logic [SEG_W-1:0] idx);
    logic [VAL_W-1:0] v;
    case (idx)
      5'd0:  v = 24'd12250000;
      5'd1:  v = 24'd11120000;
      5'd2:  v = 24'd10070000;
      5'd3:  v = 24'd9093000;
      5'd4:  v = 24'd8194000;
      5'd5:  v = 24'd7364000;
      5'd6:  v = 24'd6601000;
      5'd7:  v = 24'd5900000;
      5'd8:  v = 24'd5258000;
      5'd9:  v = 24'd4671000;
      5'd10: v = 24'd4135000;
      5'd11: v = 24'd1948000;
      5'd12: v = 24'd889100;
      5'd13: v = 24'd400800;
      5'd14: v = 24'd184100;
      5'd15: v = 24'd39960;
      5'd16: v = 24'd10270;
      5'd17: v = 24'd3097;
      5'd18: v = 24'd828;
      5'd19: v = 24'd185;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/altitude_table_interpolator_unit.sv
// top level of the altitude table interpolator
//
//   channel   signals                                   flow
//   request   start, busy, altitude                     in, taken when start && !busy
//   result    done, gravity, air_density, out_of_range  out, one cycle per strobe
//
// the front end scans one breakpoint segment per cycle, among 19 segments, and then
// makes one queue push; the back end runs a multiply step, divider steps and a final step.
// sustained rate is set by the 24-step divider; an out of range request skips the divider,
// and the front end can search a new request while the back end still works on earlier
// ones, which wait in the queue.
// busy is high while the front end searches or pushes, and longer while the
// two-entry queue is full.
// synchronous reset clears all control state; results cannot be stalled.
module altitude_table_interpolator_unit #(
  parameter int TABLE_POINTS = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [atip_pkg::ALT_W-1:0]  altitude,
  output logic                               done,
  output logic [atip_pkg::VAL_W-1:0]         gravity,
  output logic [atip_pkg::VAL_W-1:0]         air_density,
  output logic                               out_of_range
);
  import atip_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t push_entry, pop_entry;

  atip_front #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .altitude   (altitude),
    .busy       (busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  atip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  atip_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .done         (done),
    .gravity      (gravity),
    .air_density  (air_density),
    .out_of_range (out_of_range)
  );

endmodule

// File: rtl/atip_front.sv
// front end: takes a request, searches the breakpoint segments, queues the outcome
module atip_front #(
  parameter int TABLE_POINTS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [atip_pkg::ALT_W-1:0] altitude,
  output logic                         busy,
  output logic                         push_valid,
  input  logic                         push_ready,
  output atip_pkg::q_entry_t           push_entry
);
  import atip_pkg::*;

  localparam int UsedPoints = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS :
                              ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
  localparam logic [SEG_W-1:0] LastSeg = SEG_W'(UsedPoints - 2);

  front_state_t state, state_next;
  logic signed [ALT_W-1:0] alt;
  logic [SEG_W-1:0] seg;
  q_entry_t ent;
  logic signed [ALT_W-1:0] d0, d1;
  logic hit;
  logic [ALT_W-1:0] off_full;

  assign d0 = alt_pt(seg);
  assign d1 = alt_pt(SEG_W'(seg + 1'b1));
  assign hit = (alt >= d0) && (alt <= d1);
  assign off_full = alt - d0;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:   if (start) state_next = F_SEARCH;
      F_SEARCH: if (hit || seg == LastSeg) state_next = F_PUSH;
      F_PUSH:   if (push_ready) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != F_IDLE);
    push_valid = (state == F_PUSH);
    push_entry = ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (start) begin
          alt <= altitude;
          seg <= '0;
        end
      end
      F_SEARCH: begin
        if (hit) begin
          ent.oor <= 1'b0;
          ent.seg <= seg;
          ent.off <= off_full[OFF_W-1:0];
        end else if (seg == LastSeg) begin
          ent.oor <= 1'b1;
          ent.seg <= '0;
          ent.off <= '0;
        end else begin
          seg <= seg + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/atip_queue.sv
// two-entry queue between the search front end and the arithmetic back end
`include "altitude_table_interpolator_unit_macros.svh"
module atip_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  atip_pkg::q_entry_t push_entry,
  output logic               pop_valid,
  input  logic               pop_ready,
  output atip_pkg::q_entry_t pop_entry
);
  import atip_pkg::*;

  q_entry_t slots [Q_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic push, pop;

  assign push_ready = (count != QCNT_W'(Q_DEPTH));
  assign pop_valid = (count != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_entry;
  end

  `ATIU_CHECK_SAME(a_q_count_bound, 1'b1, count <= QCNT_W'(Q_DEPTH))
  `ATIU_CHECK_SAME(a_q_empty_ptrs, count == '0, wptr == rptr)
  `ATIU_CHECK_NEXT(a_q_pop_drains, pop && !push, count == QCNT_W'($past(count) - 1'b1))

endmodule

// File: rtl/atip_back.sv
// back end: scales the segment deltas and divides both tables with a serial divider
`include "altitude_table_interpolator_unit_macros.svh"
module atip_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  atip_pkg::q_entry_t           pop_entry,
  output logic                         done,
  output logic [atip_pkg::VAL_W-1:0]   gravity,
  output logic [atip_pkg::VAL_W-1:0]   air_density,
  output logic                         out_of_range
);
  import atip_pkg::*;

  back_state_t state, state_next;
  q_entry_t ent;
  logic [STEP_W-1:0] step;
  logic [OFF_W-1:0] span;
  logic gneg, dneg;
  logic [PROD_W-1:0] remg, remd;
  logic [QUO_W-1:0] qg, qd;
  logic fin;

  logic signed [ALT_W-1:0] d0, d1;
  logic [ALT_W-1:0] span_full;
  logic [VAL_W-1:0] g0, g1, r0g, r0d, r1d;
  logic [VAL_W:0] gdiff, ddiff;
  logic [VAL_W-1:0] gmag, dmag;
  logic [PROD_W-1:0] span_sh;
  logic g_ge, d_ge;
  logic [VAL_W-1:0] g_res, d_res;

  // segment ends of the latched entry
  assign d0 = alt_pt(ent.seg);
  assign d1 = alt_pt(SEG_W'(ent.seg + 1'b1));
  assign span_full = d1 - d0;
  assign g0 = grav_pt(ent.seg);
  assign g1 = grav_pt(SEG_W'(ent.seg + 1'b1));
  assign r0g = g0;
  assign r0d = dens_pt(ent.seg);
  assign r1d = dens_pt(SEG_W'(ent.seg + 1'b1));
  assign gdiff = {1'b0, g1} - {1'b0, g0};
  assign ddiff = {1'b0, r1d} - {1'b0, r0d};
  assign gmag = gdiff[VAL_W] ? VAL_W'(-gdiff) : gdiff[VAL_W-1:0];
  assign dmag = ddiff[VAL_W] ? VAL_W'(-ddiff) : ddiff[VAL_W-1:0];

  // restoring division, one quotient bit per cycle, highest bit first
  assign span_sh = PROD_W'(span) << step;
  assign g_ge = (remg >= span_sh);
  assign d_ge = (remd >= span_sh);

  // quotients are magnitudes, so truncation is toward zero
  assign g_res = gneg ? (r0g - qg) : (r0g + qg);
  assign d_res = dneg ? (r0d - qd) : (r0d + qd);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (pop_valid) state_next = B_MUL;
      B_MUL: begin
        if (ent.oor || span_full == '0) state_next = B_FIN;
        else state_next = B_DIV;
      end
      B_DIV:   if (step == '0) state_next = B_FIN;
      B_FIN:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state == B_IDLE);
    fin = (state == B_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop_valid) ent <= pop_entry;
      end
      B_MUL: begin
        span <= span_full[OFF_W-1:0];
        gneg <= gdiff[VAL_W];
        dneg <= ddiff[VAL_W];
        remg <= PROD_W'(gmag) * PROD_W'(ent.off);
        remd <= PROD_W'(dmag) * PROD_W'(ent.off);
        qg <= '0;
        qd <= '0;
        step <= STEP_W'(QUO_W - 1);
      end
      B_DIV: begin
        if (g_ge) remg <= remg - span_sh;
        if (d_ge) remd <= remd - span_sh;
        qg <= {qg[QUO_W-2:0], g_ge};
        qd <= {qd[QUO_W-2:0], d_ge};
        step <= step - 1'b1;
      end
      B_FIN: begin
        if (ent.oor) begin
          gravity <= '0;
          air_density <= '0;
        end else if (span_full == '0) begin
          // degenerate segment gives its first value
          gravity <= r0g;
          air_density <= r0d;
        end else begin
          gravity <= g_res;
          air_density <= d_res;
        end
        out_of_range <= ent.oor;
      end
      default: begin
      end
    endcase
  end

  `ATIU_CHECK_SAME(a_oor_zero, done, !out_of_range || (gravity == '0 && air_density == '0))
  `ATIU_CHECK_NEXT(a_done_single, done, !done)
  `ATIU_CHECK_NEXT(a_div_ends, state == B_DIV && step == '0, state == B_FIN)

endmodule
